// File: rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none
package ffha_pkg;

  localparam int GranW   = 12;             // granule index width
  localparam int LenW    = 13;             // block length width, holds the whole heap
  localparam int AddrW   = 6;              // free table address width
  localparam int CountW  = 7;              // free table fill count width
  localparam int TotW    = 17;             // byte total width
  localparam int HdrW    = LenW + 1;

  localparam logic [LenW-1:0]   HeapGranules   = 13'd4096;
  localparam logic [CountW-1:0] MaxFreeEntries = 7'd64;
  localparam logic [GranW-1:0]  LastGranule    = 12'd4095;
  localparam logic [3:0]        HdrOffset      = 4'd8;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StZero   = 3'd1;
  localparam logic [2:0] StNoFit  = 3'd2;
  localparam logic [2:0] StDouble = 3'd3;
  localparam logic [2:0] StBad    = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [15:0] req_bytes;
    logic [15:0] user_offset;
  } in_t;

  typedef struct packed {
    logic [15:0]       result_offset;
    logic [2:0]        status;
    logic [TotW-1:0]   used_bytes;
    logic [TotW-1:0]   avail_bytes;
    logic [CountW-1:0] free_blocks;
  } out_t;

  typedef struct packed {
    logic [GranW-1:0] start;
    logic [LenW-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic             zero_size;
    logic [LenW-1:0]  need;
    logic             align_ok;
    logic [GranW-1:0] granule;
  } dec_t;

endpackage
`default_nettype wire

// File: rtl/core/ffha_decode.sv
// Request decode: block size in granules and pointer checks.
// Depends on ffha_pkg.
`default_nettype none
module ffha_decode (
  input  wire  logic [15:0]   req_bytes_i,
  input  wire  logic [15:0]   user_offset_i,
  output ffha_pkg::dec_t      dec_o
);

  logic [16:0] padded;

  // Size plus the 8-byte header, rounded up to whole granules.
  assign padded = {1'b0, req_bytes_i} + 17'd23;

  assign dec_o.zero_size = (req_bytes_i == 16'd0);
  assign dec_o.need      = padded[16:4];
  assign dec_o.align_ok  = (user_offset_i[3:0] == ffha_pkg::HdrOffset);
  assign dec_o.granule   = user_offset_i[15:4];

endmodule
`default_nettype wire

// File: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator over 4096 granules of 16 bytes with a 64-entry free table.
// Allocate scans the free entries in order, then may shift later entries down one slot;
// free checks the block header, scans the table, then may shift entries up or down one slot.
// One request at a time; the single-port table read loop sets the rate.
// Reset: a clearing pass of 4096 cycles writes the header store before the first word.
// Depends on ffha_pkg and ffha_decode.
`default_nettype none
module first_fit_heap_allocator (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  logic           in_valid_i,
  output logic                 in_ready_o,
  input  wire  ffha_pkg::in_t  in_i,
  output logic                 out_valid_o,
  input  wire  logic           out_ready_i,
  output ffha_pkg::out_t       out_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_RD, S_A_CMP, S_F_HRD, S_F_HCHK, S_F_RD, S_F_CMP,
    S_F_DEC, S_SH_RD, S_SH_WR, S_WR_ENT, S_HDR1, S_HDR2, S_DONE
  } state_e;

  localparam int GW = ffha_pkg::GranW;
  localparam int LW = ffha_pkg::LenW;
  localparam int AW = ffha_pkg::AddrW;
  localparam int CW = ffha_pkg::CountW;
  localparam int TW = ffha_pkg::TotW;
  localparam int HW = ffha_pkg::HdrW;

  // Free table and header store, both with registered reads.
  ffha_pkg::entry_t tab_mem [2**AW];
  logic [HW-1:0]    hdr_mem [2**GW];

  ffha_pkg::entry_t tab_rdata_q;
  logic [HW-1:0]    hdr_rdata_q;
  logic [AW-1:0]    tab_raddr;
  logic             tab_we;
  logic [AW-1:0]    tab_waddr;
  ffha_pkg::entry_t tab_wdata;
  logic             hdr_we;
  logic [GW-1:0]    hdr_waddr;
  logic [HW-1:0]    hdr_wdata;

  state_e           state_q;
  logic [GW-1:0]    clr_q;
  logic [LW-1:0]    need_q;
  logic [GW-1:0]    g_q;
  logic [LW-1:0]    s_q;
  logic [CW-1:0]    idx_q;
  logic [CW-1:0]    pstop_q;
  logic [CW-1:0]    lim_q;
  logic             sh_en_q;
  logic             sh_dn_q;
  logic [CW-1:0]    entries_q;
  ffha_pkg::entry_t prev_q;
  ffha_pkg::entry_t cur_q;
  logic             cur_ok_q;
  logic [2:0]       status_q;
  logic [15:0]      off_q;
  logic [TW-1:0]    alloc_q;
  logic [TW-1:0]    free_q;
  logic             ent_en_q;
  logic [AW-1:0]    ent_addr_q;
  ffha_pkg::entry_t ent_data_q;
  logic             hw1_en_q;
  logic [GW-1:0]    hw1_addr_q;
  logic [HW-1:0]    hw1_data_q;
  logic             hw2_en_q;
  logic [GW-1:0]    hw2_addr_q;
  logic [HW-1:0]    hw2_data_q;
  logic             out_valid_q;
  ffha_pkg::out_t   out_q;

  ffha_pkg::dec_t   dec;

  ffha_decode u_decode (
    .req_bytes_i   (in_i.req_bytes),
    .user_offset_i (in_i.user_offset),
    .dec_o         (dec)
  );

  // Shared compare and add terms used by the scan and merge steps.
  logic [LW-1:0]  prev_end;
  logic [LW-1:0]  g_plus_s;
  logic [HW-1:0]  hdr_end;
  logic           pred;
  logic           succ;
  logic [TW-1:0]  s_bytes;
  logic [CW-1:0]  idx_m1;
  logic [CW-1:0]  idx_p1;

  assign prev_end = {1'b0, prev_q.start} + prev_q.len;
  assign g_plus_s = {1'b0, g_q} + s_q;
  assign hdr_end  = {2'b00, g_q} + {1'b0, hdr_rdata_q[HW-1:1]};
  assign pred     = (idx_q != '0) && (prev_end == {1'b0, g_q});
  assign succ     = cur_ok_q && (g_plus_s == {1'b0, cur_q.start});
  assign s_bytes  = {s_q, 4'b0000};
  assign idx_m1   = idx_q - 7'd1;
  assign idx_p1   = idx_q + 7'd1;

  // The shift engine reads the neighbour of the current slot; scans read the slot itself.
  always_comb begin
    tab_raddr = idx_q[AW-1:0];
    if (state_q == S_SH_RD) begin
      tab_raddr = sh_dn_q ? idx_p1[AW-1:0] : idx_m1[AW-1:0];
    end
  end

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = ent_addr_q;
    tab_wdata = ent_data_q;
    hdr_we    = 1'b0;
    hdr_waddr = hw1_addr_q;
    hdr_wdata = hw1_data_q;
    case (state_q)
      S_CLR: begin
        hdr_we    = 1'b1;
        hdr_waddr = clr_q;
        hdr_wdata = (clr_q == '0) ? {ffha_pkg::HeapGranules, 1'b0} : '0;
        tab_we    = (clr_q == '0);
        tab_waddr = '0;
        tab_wdata = '{start: '0, len: ffha_pkg::HeapGranules};
      end
      S_SH_WR: begin
        tab_we    = 1'b1;
        tab_waddr = idx_q[AW-1:0];
        tab_wdata = tab_rdata_q;
      end
      S_WR_ENT: tab_we = ent_en_q;
      S_HDR1:   hdr_we = hw1_en_q;
      S_HDR2: begin
        hdr_we    = hw2_en_q;
        hdr_waddr = hw2_addr_q;
        hdr_wdata = hw2_data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    hdr_rdata_q <= hdr_mem[g_q];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequencer. Every request ends in S_DONE, which hands the word to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      entries_q   <= 7'd1;
      alloc_q     <= '0;
      free_q      <= {ffha_pkg::HeapGranules, 4'b0000};
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      sh_en_q     <= 1'b0;
      ent_en_q    <= 1'b0;
      hw1_en_q    <= 1'b0;
      hw2_en_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 12'd1;
          if (clr_q == ffha_pkg::LastGranule) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            need_q   <= dec.need;
            g_q      <= dec.granule;
            off_q    <= '0;
            status_q <= ffha_pkg::StOk;
            idx_q    <= '0;
            sh_en_q  <= 1'b0;
            ent_en_q <= 1'b0;
            hw1_en_q <= 1'b0;
            hw2_en_q <= 1'b0;
            cur_ok_q <= 1'b0;
            if (in_i.cmd == ffha_pkg::CmdAlloc) begin
              if (dec.zero_size) begin
                status_q <= ffha_pkg::StZero;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_A_RD;
              end
            end else if (!dec.align_ok) begin
              status_q <= ffha_pkg::StBad;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_F_HRD;
            end
          end
        end
        S_A_RD: begin
          if (idx_q >= entries_q) begin
            status_q <= ffha_pkg::StNoFit;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_A_CMP;
          end
        end
        S_A_CMP: begin
          if (tab_rdata_q.len >= need_q) begin
            off_q      <= {tab_rdata_q.start, ffha_pkg::HdrOffset};
            state_q    <= S_SH_RD;
            if (tab_rdata_q.len != need_q) begin
              // Split: the remainder stays in this slot right after the new block.
              ent_en_q   <= 1'b1;
              ent_addr_q <= idx_q[AW-1:0];
              ent_data_q <= '{start: tab_rdata_q.start + need_q[GW-1:0],
                              len: tab_rdata_q.len - need_q};
              hw1_en_q   <= 1'b1;
              hw1_addr_q <= tab_rdata_q.start + need_q[GW-1:0];
              hw1_data_q <= {tab_rdata_q.len - need_q, 1'b0};
              hw2_en_q   <= 1'b1;
              hw2_addr_q <= tab_rdata_q.start;
              hw2_data_q <= {need_q, 1'b1};
              alloc_q    <= alloc_q + {need_q, 4'b0000};
              free_q     <= free_q - {need_q, 4'b0000};
            end else begin
              // Exact fit: the slot is dropped and later entries move down.
              sh_en_q    <= 1'b1;
              sh_dn_q    <= 1'b1;
              lim_q      <= entries_q;
              entries_q  <= entries_q - 7'd1;
              hw1_en_q   <= 1'b1;
              hw1_addr_q <= tab_rdata_q.start;
              hw1_data_q <= {tab_rdata_q.len, 1'b1};
              alloc_q    <= alloc_q + {tab_rdata_q.len, 4'b0000};
              free_q     <= free_q - {tab_rdata_q.len, 4'b0000};
            end
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_A_RD;
          end
        end
        S_F_HRD: state_q <= S_F_HCHK;
        S_F_HCHK: begin
          s_q <= hdr_rdata_q[HW-1:1];
          if (!hdr_rdata_q[0]) begin
            status_q <= ffha_pkg::StDouble;
            state_q  <= S_DONE;
          end else if ((hdr_rdata_q[HW-1:1] == '0) ||
                       (hdr_end > {1'b0, ffha_pkg::HeapGranules})) begin
            status_q <= ffha_pkg::StBad;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_F_RD;
          end
        end
        S_F_RD: begin
          state_q <= (idx_q >= entries_q) ? S_F_DEC : S_F_CMP;
        end
        S_F_CMP: begin
          if (tab_rdata_q.start > g_q) begin
            cur_q    <= tab_rdata_q;
            cur_ok_q <= 1'b1;
            state_q  <= S_F_DEC;
          end else begin
            prev_q  <= tab_rdata_q;
            idx_q   <= idx_p1;
            state_q <= S_F_RD;
          end
        end
        S_F_DEC: begin
          // The freed block's own header ends up free with its own size, unless a full table has no merge.
          hw1_en_q   <= 1'b1;
          hw1_addr_q <= g_q;
          hw1_data_q <= {s_q, 1'b0};
          state_q    <= S_SH_RD;
          if (pred) begin
            ent_en_q   <= 1'b1;
            ent_addr_q <= idx_m1[AW-1:0];
            hw1_addr_q <= prev_q.start;
            hw2_en_q   <= 1'b1;
            hw2_addr_q <= g_q;
            hw2_data_q <= {s_q, 1'b0};
            if (succ) begin
              ent_data_q <= '{start: prev_q.start, len: prev_q.len + s_q + cur_q.len};
              hw1_data_q <= {prev_q.len + s_q + cur_q.len, 1'b0};
              sh_en_q    <= 1'b1;
              sh_dn_q    <= 1'b1;
              lim_q      <= entries_q;
              entries_q  <= entries_q - 7'd1;
            end else begin
              ent_data_q <= '{start: prev_q.start, len: prev_q.len + s_q};
              hw1_data_q <= {prev_q.len + s_q, 1'b0};
            end
          end else if (succ) begin
            ent_en_q   <= 1'b1;
            ent_addr_q <= idx_q[AW-1:0];
            ent_data_q <= '{start: g_q, len: cur_q.len + s_q};
          end else if (entries_q >= ffha_pkg::MaxFreeEntries) begin
            hw1_en_q <= 1'b0;
            status_q <= ffha_pkg::StBad;
            state_q  <= S_DONE;
          end else begin
            // New entry: move the tail up one slot, then write it in place.
            ent_en_q   <= 1'b1;
            ent_addr_q <= idx_q[AW-1:0];
            ent_data_q <= '{start: g_q, len: s_q};
            sh_en_q    <= 1'b1;
            sh_dn_q    <= 1'b0;
            pstop_q    <= idx_q;
            idx_q      <= entries_q;
            entries_q  <= entries_q + 7'd1;
          end
          if (pred || succ || (entries_q < ffha_pkg::MaxFreeEntries)) begin
            alloc_q <= alloc_q - s_bytes;
            free_q  <= free_q + s_bytes;
          end
        end
        S_SH_RD: begin
          if (sh_en_q && (sh_dn_q ? (idx_p1 < lim_q) : (idx_q > pstop_q))) begin
            state_q <= S_SH_WR;
          end else begin
            state_q <= S_WR_ENT;
          end
        end
        S_SH_WR: begin
          idx_q   <= sh_dn_q ? idx_p1 : idx_m1;
          state_q <= S_SH_RD;
        end
        S_WR_ENT: state_q <= S_HDR1;
        S_HDR1:   state_q <= S_HDR2;
        S_HDR2:   state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.result_offset <= off_q;
            out_q.status        <= status_q;
            out_q.used_bytes    <= alloc_q;
            out_q.avail_bytes   <= free_q;
            out_q.free_blocks   <= entries_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
